@@ hw/rtl/tnc_pkg.sv @@
// Shared types and constants for the tag nesting checker.
// Used by tnc_parse, tnc_stack and tag_nesting_checker_core; depends on nothing.
package tnc_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Tag letters: 0..25 for A..Z, NO_TAG for none
   localparam int LETTER_W = 5;
   localparam logic [LETTER_W-1:0] NO_TAG = 5'd26;

   // Characters of interest
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SLASH   = 8'd47;
   localparam logic [7:0] CH_OPEN    = 8'd60;
   localparam logic [7:0] CH_CLOSE   = 8'd62;
   localparam logic [7:0] CH_A       = 8'd65;
   localparam logic [7:0] CH_Z       = 8'd90;

   // Line status codes
   typedef enum logic [2:0] {
      ST_CORRECT     = 3'd0,
      ST_WRONG_ORDER = 3'd1,
      ST_EXTRA_CLOSE = 3'd2,
      ST_UNCLOSED    = 3'd3,
      ST_NO_TAGS     = 3'd4,
      ST_OVERFLOW    = 3'd5
   } line_status_type;

   // Tag events from the parser, valid for one cycle
   typedef struct packed {
      logic                nl;      // end of line
      logic                push;    // opening tag completed
      logic                close;   // closing tag letter arrived
      logic [LETTER_W-1:0] letter;
   } tnc_event_type;

   // Line summary given at end of line
   typedef struct packed {
      line_status_type     status;
      logic [LETTER_W-1:0] expected;
      logic [LETTER_W-1:0] found;
   } tnc_result_type;

endpackage

@@ hw/rtl/tag_nesting_checker_core.sv @@
// Top level of the tag nesting checker: request register, parser, stack, response register.
// Depends on tnc_pkg, tnc_parse and tnc_stack.
//
//   channel | ports                                              | direction
//   req     | req_valid, req_ready, req_text_byte                | in
//   rsp     | rsp_valid, rsp_ready, rsp_line_status,             | out
//           | rsp_expected_tag, rsp_found_tag                    |
//
// One request per cycle is accepted unless a newline stalls; each byte is handled while it
// sits in the request register, with a single stack-top compare and push or pop.
// Only a newline produces a response, loaded at the edge that processes the newline.
// A newline held behind an untaken response stalls the request side.
// Reset (synchronous) empties the stack and both pipeline registers.
module tag_nesting_checker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_line_status,
   output logic [tnc_pkg::LETTER_W-1:0]  rsp_expected_tag,
   output logic [tnc_pkg::LETTER_W-1:0]  rsp_found_tag
);

   logic                         in_valid_ff;
   logic [7:0]                   in_byte_ff;
   logic                         is_nl;
   logic                         fire;
   logic                         rsp_valid_ff;
   tnc_pkg::tnc_result_type      rsp_ff;
   tnc_pkg::tnc_event_type       ev;
   tnc_pkg::tnc_result_type      result;

   // Advance the held byte unless it is a newline facing a full, untaken response slot
   assign is_nl     = (in_byte_ff == tnc_pkg::CH_NEWLINE);
   assign fire      = in_valid_ff && (!is_nl || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // Capture requests
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_text_byte;
      end
   end

   tnc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (in_byte_ff),
      .ev        (ev)
   );

   tnc_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .ev     (ev),
      .result (result)
   );

   // Load the response at end of line, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev.nl) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev.nl) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_status  = rsp_ff.status;
   assign rsp_expected_tag = rsp_ff.expected;
   assign rsp_found_tag    = rsp_ff.found;

`ifndef ASSERT_OFF
   a_nl_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && is_nl && rsp_valid_ff && !rsp_ready) |-> !req_ready && !ev.nl)
      else $error("newline advanced over an untaken response");

   a_rsp_from_nl: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ev.nl))
      else $error("response without end of line");

   a_nonl_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !is_nl) |-> req_ready)
      else $error("ordinary byte stalled the request side");
`endif

endmodule

@@ hw/rtl/tnc_parse.sv @@
// Tag parser: tracks where a byte falls relative to '<', '</' and '>'.
// Depends on tnc_pkg; emits tnc_pkg::tnc_event_type for the stack unit.
module tnc_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           text_byte,
   output tnc_pkg::tnc_event_type ev
);

   typedef enum logic [1:0] {
      PH_OUTSIDE  = 2'd0,
      PH_LT       = 2'd1,
      PH_LT_SLASH = 2'd2,
      PH_OPEN_TAG = 2'd3
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [tnc_pkg::LETTER_W-1:0]    pending_ff, pending_in;
   logic                            is_upper;
   logic [tnc_pkg::LETTER_W-1:0]    letter;
   logic [7:0]                      byte_off;
   logic                            push_c, close_c;

   // Classify the byte
   assign is_upper = (text_byte >= tnc_pkg::CH_A) && (text_byte <= tnc_pkg::CH_Z);
   assign byte_off = text_byte - tnc_pkg::CH_A;
   assign letter   = is_upper ? byte_off[tnc_pkg::LETTER_W-1:0] : '0;

   // Next phase and tag events
   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      push_c     = 1'b0;
      close_c    = 1'b0;
      if (text_byte == tnc_pkg::CH_NEWLINE) begin
         phase_in   = PH_OUTSIDE;
         pending_in = '0;
      end else begin
         case (phase_ff)
            PH_LT: begin
               if (text_byte == tnc_pkg::CH_SLASH) begin
                  phase_in = PH_LT_SLASH;
               end else if (is_upper) begin
                  pending_in = letter;
                  phase_in   = PH_OPEN_TAG;
               end else if (text_byte != tnc_pkg::CH_OPEN) begin
                  phase_in = PH_OUTSIDE;
               end
            end
            PH_LT_SLASH: begin
               if (is_upper) begin
                  close_c  = 1'b1;
                  phase_in = PH_OUTSIDE;
               end else if (text_byte == tnc_pkg::CH_OPEN) begin
                  phase_in = PH_LT;
               end else begin
                  phase_in = PH_OUTSIDE;
               end
            end
            PH_OPEN_TAG: begin
               if (text_byte == tnc_pkg::CH_CLOSE) begin
                  push_c   = 1'b1;
                  phase_in = PH_OUTSIDE;
               end else if (text_byte == tnc_pkg::CH_OPEN) begin
                  phase_in = PH_LT;
               end
            end
            default: begin
               if (text_byte == tnc_pkg::CH_OPEN) begin
                  phase_in = PH_LT;
               end
            end
         endcase
      end
   end

   // Events count only on an advancing request
   assign ev.nl     = fire && (text_byte == tnc_pkg::CH_NEWLINE);
   assign ev.push   = fire && push_c;
   assign ev.close  = fire && close_c;
   assign ev.letter = push_c ? pending_ff : letter;

   // Hold phase and pending letter
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OUTSIDE;
         pending_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

@@ hw/rtl/tnc_stack.sv @@
// Open-tag stack with first-error capture and end-of-line summary.
// Depends on tnc_pkg; consumes events from tnc_parse.
module tnc_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  tnc_pkg::tnc_event_type ev,
   output tnc_pkg::tnc_result_type result
);

   logic [tnc_pkg::LETTER_W-1:0] stack_ff [tnc_pkg::STACK_DEPTH];
   logic [tnc_pkg::CNT_W-1:0]    count_ff, count_in;
   tnc_pkg::line_status_type     err_ff, err_in;
   logic [tnc_pkg::LETTER_W-1:0] err_exp_ff, err_exp_in;
   logic [tnc_pkg::LETTER_W-1:0] err_fnd_ff, err_fnd_in;
   logic                         seen_ff, seen_in;
   logic                         wr_en;
   logic [tnc_pkg::CNT_W-1:0]    top_pos;
   logic [tnc_pkg::LETTER_W-1:0] top;
   logic                         empty, full;

   // Read the top entry
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == tnc_pkg::CNT_W'(tnc_pkg::STACK_DEPTH));
   assign top_pos = count_ff - tnc_pkg::CNT_W'(1);
   assign top     = stack_ff[top_pos[tnc_pkg::IDX_W-1:0]];

   // Update count and keep the first error of the line
   always_comb begin
      count_in   = count_ff;
      err_in     = err_ff;
      err_exp_in = err_exp_ff;
      err_fnd_in = err_fnd_ff;
      seen_in    = seen_ff;
      wr_en      = 1'b0;
      if (ev.nl) begin
         count_in   = '0;
         err_in     = tnc_pkg::ST_CORRECT;
         err_exp_in = tnc_pkg::NO_TAG;
         err_fnd_in = tnc_pkg::NO_TAG;
         seen_in    = 1'b0;
      end else if (ev.push) begin
         seen_in = 1'b1;
         if (full) begin
            if (err_ff == tnc_pkg::ST_CORRECT) begin
               err_in     = tnc_pkg::ST_OVERFLOW;
               err_exp_in = ev.letter;
               err_fnd_in = tnc_pkg::NO_TAG;
            end
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + tnc_pkg::CNT_W'(1);
         end
      end else if (ev.close) begin
         seen_in = 1'b1;
         if (empty) begin
            if (err_ff == tnc_pkg::ST_CORRECT) begin
               err_in     = tnc_pkg::ST_EXTRA_CLOSE;
               err_exp_in = tnc_pkg::NO_TAG;
               err_fnd_in = ev.letter;
            end
         end else begin
            if ((top != ev.letter) && (err_ff == tnc_pkg::ST_CORRECT)) begin
               err_in     = tnc_pkg::ST_WRONG_ORDER;
               err_exp_in = top;
               err_fnd_in = ev.letter;
            end
            count_in = top_pos;
         end
      end
   end

   // Summarize the line
   always_comb begin
      if (err_ff != tnc_pkg::ST_CORRECT) begin
         result.status   = err_ff;
         result.expected = err_exp_ff;
         result.found    = err_fnd_ff;
      end else if (!empty) begin
         result.status   = tnc_pkg::ST_UNCLOSED;
         result.expected = top;
         result.found    = tnc_pkg::NO_TAG;
      end else if (!seen_ff) begin
         result.status   = tnc_pkg::ST_NO_TAGS;
         result.expected = tnc_pkg::NO_TAG;
         result.found    = tnc_pkg::NO_TAG;
      end else begin
         result.status   = tnc_pkg::ST_CORRECT;
         result.expected = tnc_pkg::NO_TAG;
         result.found    = tnc_pkg::NO_TAG;
      end
   end

   // Write pushed letters
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[count_ff[tnc_pkg::IDX_W-1:0]] <= ev.letter;
      end
   end

   // Hold line state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         err_ff     <= tnc_pkg::ST_CORRECT;
         err_exp_ff <= tnc_pkg::NO_TAG;
         err_fnd_ff <= tnc_pkg::NO_TAG;
         seen_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         err_ff     <= err_in;
         err_exp_ff <= err_exp_in;
         err_fnd_ff <= err_fnd_in;
         seen_ff    <= seen_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tnc_pkg::CNT_W'(tnc_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      ev.nl |=> (count_ff == '0) && (err_ff == tnc_pkg::ST_CORRECT) && !seen_ff)
      else $error("line state not cleared at end of line");

   a_first_error_kept: assert property (@(posedge clock) disable iff (reset)
      (err_ff != tnc_pkg::ST_CORRECT) && !ev.nl |=> $stable(err_ff) && $stable(err_exp_ff))
      else $error("first error of line overwritten");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ev.nl, ev.push, ev.close}))
      else $error("more than one tag event in a cycle");
`endif

endmodule

@@ bench/tag_nesting_checker_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for tag_nesting_checker_core: streams text bytes in over req and checks every
// per-line report on rsp against a nesting tracker kept inside the bench.
// Depends on tnc_pkg and the tag_nesting_checker_core RTL.
module tag_nesting_checker_core_tb;

   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TOTAL_BYTES  = 1450;
   localparam int IDLE_PCT     = 27;
   localparam int STALL_CYCLES = 400;
   localparam int SETTLE       = 20;
   localparam int LW           = tnc_pkg::LETTER_W;

   typedef enum int {SCAN_TEXT, SCAN_LT, SCAN_LT_SLASH, SCAN_OPEN_TAG} scan_phase_type;

   typedef struct {
      logic [7:0] text_byte;
      bit         drain_first;   // hold this request until every report is in
   } text_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_text_byte = 8'd0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [2:0]          rsp_line_status;
   logic [LW-1:0]       rsp_expected_tag;
   logic [LW-1:0]       rsp_found_tag;

   text_req_type            pending_q [$];
   tnc_pkg::tnc_result_type line_reports_q [$];
   bit                      drain_next;
   int                      bytes_sent;
   int                      reports_seen;
   int                      stall_left;
   bit                      stall_done;
   int                      errors;
   int                      cycles;
   tnc_pkg::tnc_result_type want;

   // Nesting tracker state
   logic [LW-1:0]            open_letters [tnc_pkg::STACK_DEPTH];
   int                       open_depth;
   scan_phase_type           scan_phase;
   logic [LW-1:0]            held_letter;
   bit                       held_valid;
   tnc_pkg::line_status_type line_error;
   logic [LW-1:0]            error_expected;
   logic [LW-1:0]            error_found;
   bit                       line_has_tags;

   tag_nesting_checker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_status  (rsp_line_status),
      .rsp_expected_tag (rsp_expected_tag),
      .rsp_found_tag    (rsp_found_tag)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void clear_line_state();
      open_depth     = 0;
      scan_phase     = SCAN_TEXT;
      held_letter    = '0;
      held_valid     = 1'b0;
      line_error     = tnc_pkg::ST_CORRECT;
      error_expected = tnc_pkg::NO_TAG;
      error_found    = tnc_pkg::NO_TAG;
      line_has_tags  = 1'b0;
   endfunction

   // Keep only the first error of a line
   function automatic void note_line_error(tnc_pkg::line_status_type code,
                                           logic [LW-1:0] exp_tag,
                                           logic [LW-1:0] fnd_tag);
      if (line_error == tnc_pkg::ST_CORRECT) begin
         line_error     = code;
         error_expected = exp_tag;
         error_found    = fnd_tag;
      end
   endfunction

   // Advance the tracker by one accepted byte; queue a report at each newline
   function automatic void scan_text_byte(logic [7:0] b);
      bit                      upper;
      logic [LW-1:0]           letter;
      tnc_pkg::tnc_result_type rpt;
      upper  = (b >= tnc_pkg::CH_A) && (b <= tnc_pkg::CH_Z);
      letter = upper ? LW'(b - tnc_pkg::CH_A) : '0;
      if (b == tnc_pkg::CH_NEWLINE) begin
         rpt.expected = tnc_pkg::NO_TAG;
         rpt.found    = tnc_pkg::NO_TAG;
         if (line_error != tnc_pkg::ST_CORRECT) begin
            rpt.status   = line_error;
            rpt.expected = error_expected;
            rpt.found    = error_found;
         end else if (open_depth > 0) begin
            rpt.status   = tnc_pkg::ST_UNCLOSED;
            rpt.expected = open_letters[open_depth-1];
         end else if (!line_has_tags) begin
            rpt.status = tnc_pkg::ST_NO_TAGS;
         end else begin
            rpt.status = tnc_pkg::ST_CORRECT;
         end
         line_reports_q.push_back(rpt);
         clear_line_state();
         return;
      end
      case (scan_phase)
         SCAN_LT: begin
            if (b == tnc_pkg::CH_SLASH) begin
               scan_phase = SCAN_LT_SLASH;
            end else if (upper) begin
               held_letter = letter;
               held_valid  = 1'b1;
               scan_phase  = SCAN_OPEN_TAG;
            end else if (b != tnc_pkg::CH_OPEN) begin
               scan_phase = SCAN_TEXT;
            end
         end
         SCAN_LT_SLASH: begin
            if (upper) begin
               // Compare the closing letter with the top at once; pop even on mismatch
               line_has_tags = 1'b1;
               if (open_depth == 0) begin
                  note_line_error(tnc_pkg::ST_EXTRA_CLOSE, tnc_pkg::NO_TAG, letter);
               end else begin
                  if (open_letters[open_depth-1] != letter)
                     note_line_error(tnc_pkg::ST_WRONG_ORDER,
                                     open_letters[open_depth-1], letter);
                  open_depth--;
               end
               scan_phase = SCAN_TEXT;
            end else if (b == tnc_pkg::CH_OPEN) begin
               scan_phase = SCAN_LT;
            end else begin
               scan_phase = SCAN_TEXT;
            end
         end
         SCAN_OPEN_TAG: begin
            if (b == tnc_pkg::CH_CLOSE) begin
               // Push on '>', refusing the letter when the stack is full
               if (held_valid) begin
                  line_has_tags = 1'b1;
                  if (open_depth >= tnc_pkg::STACK_DEPTH) begin
                     note_line_error(tnc_pkg::ST_OVERFLOW, held_letter, tnc_pkg::NO_TAG);
                  end else begin
                     open_letters[open_depth] = held_letter;
                     open_depth++;
                  end
               end
               held_valid = 1'b0;
               scan_phase = SCAN_TEXT;
            end else if (b == tnc_pkg::CH_OPEN) begin
               held_valid = 1'b0;
               scan_phase = SCAN_LT;
            end
         end
         default: begin
            if (b == tnc_pkg::CH_OPEN)
               scan_phase = SCAN_LT;
         end
      endcase
   endfunction

   function automatic void add_byte(logic [7:0] b);
      pending_q.push_back('{b, drain_next});
      drain_next = 1'b0;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   function automatic void add_open(logic [LW-1:0] l);
      add_byte(tnc_pkg::CH_OPEN);
      add_byte(tnc_pkg::CH_A + l);
      if ($urandom_range(3) == 0)
         add_text(" id=x");
      add_byte(tnc_pkg::CH_CLOSE);
   endfunction

   function automatic void add_close(logic [LW-1:0] l);
      add_byte(tnc_pkg::CH_OPEN);
      add_byte(tnc_pkg::CH_SLASH);
      add_byte(tnc_pkg::CH_A + l);
      if ($urandom_range(4) != 0)
         add_byte(tnc_pkg::CH_CLOSE);
   endfunction

   // Plain text between tags: printable, never '<' or newline
   function automatic void add_filler();
      logic [7:0] c;
      repeat ($urandom_range(3)) begin
         c = 8'($urandom_range(32, 126));
         add_byte((c == tnc_pkg::CH_OPEN) ? 8'd32 : c);
      end
   endfunction

   // One random line: mostly nested tags with random content, some broken, some noise
   function automatic void add_random_line();
      logic [LW-1:0] nest [$];
      logic [LW-1:0] l;
      logic [7:0]    noise_chars [10];
      int            kind;
      int            max_depth;
      bit            mutate;
      noise_chars = '{tnc_pkg::CH_OPEN, tnc_pkg::CH_OPEN, tnc_pkg::CH_SLASH,
                      tnc_pkg::CH_CLOSE, tnc_pkg::CH_A, tnc_pkg::CH_Z, 8'd77, 8'd97,
                      8'd32, tnc_pkg::CH_NEWLINE};
      kind   = $urandom_range(99);
      mutate = (kind >= 57) && (kind < 72);
      if (kind < 3) begin
         // Fill the stack to around its depth, then unwind
         repeat (tnc_pkg::STACK_DEPTH - 1 + $urandom_range(3)) begin
            l = LW'($urandom_range(25));
            nest.push_back(l);
            add_open(l);
         end
         while (nest.size() > 0)
            add_close(nest.pop_back());
      end else if (kind < 72) begin
         max_depth = $urandom_range(1, 6);
         repeat ($urandom_range(1, 12)) begin
            add_filler();
            if (nest.size() < max_depth && (nest.size() == 0 || $urandom_range(1))) begin
               l = LW'($urandom_range(25));
               nest.push_back(l);
               add_open(l);
            end else begin
               l = nest.pop_back();
               if (mutate && $urandom_range(4) == 0)
                  l = LW'($urandom_range(25));
               add_close(l);
            end
         end
         while (nest.size() > 0 && !(mutate && $urandom_range(3) == 0))
            add_close(nest.pop_back());
         if (mutate && $urandom_range(2) == 0)
            add_close(LW'($urandom_range(25)));
         add_filler();
      end else if (kind < 86) begin
         repeat ($urandom_range(1, 15))
            add_byte(noise_chars[$urandom_range(9)]);
      end else begin
         repeat ($urandom_range(1, 20))
            add_byte(8'($urandom_range(255)));
      end
      add_byte(tnc_pkg::CH_NEWLINE);
   endfunction

   // Build the request stream and run to the end
   initial begin
      clear_line_state();
      add_text("\n");                          // empty line
      add_text("hello world\n");               // text only
      add_text("<A></A>\n");                   // correct
      add_text("<A><B></A></B></C>\n");        // wrong order, later errors ignored
      add_text("</Z>\n");                      // extra close
      add_text("<Z>\n");                       // unclosed open
      add_text("<A><B></B>\n");
      add_text("<a></a><1>x</ >\n");           // no real tags
      add_text("<<A></<A>\n");                 // repeated '<' restarts the tag
      add_text("<A<B>\n");                     // new '<' drops the pending open
      add_text("<M x y>text</M\n");            // close letter checked at once
      add_text("<A>x</\n");                    // newline inside a tag
      add_text("<B\n");                        // unfinished open dropped
      add_byte(8'd0);
      add_byte(8'd255);
      add_text("<A>");
      add_byte(8'd255);
      add_text("</A>\n");
      for (int i = 0; i < tnc_pkg::STACK_DEPTH; i++)    // full stack, no overflow
         add_open(LW'(i % 26));
      add_text("\n");
      for (int i = 0; i <= tnc_pkg::STACK_DEPTH; i++)   // one open too many
         add_open(LW'(25 - (i % 26)));
      add_text("</Z></Y>\n");
      drain_next = 1'b1;
      while (pending_q.size() < TOTAL_BYTES) begin
         drain_next = drain_next || ($urandom_range(14) == 0);
         add_random_line();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || line_reports_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Sender: track accepted bytes, then offer the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            scan_text_byte(req_text_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() > 0
                && !(pending_q[0].drain_first && line_reports_q.size() > 0)
                && ((bytes_sent >= 600 && bytes_sent < 900)
                    || $urandom_range(99) >= IDLE_PCT)) begin
               req_text_byte <= pending_q[0].text_byte;
               req_valid     <= 1'b1;
               void'(pending_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each report, then choose ready for the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (line_reports_q.size() == 0) begin
               $display("%0t: unexpected report: expected none, actual %0d/%0d/%0d",
                        $time, rsp_line_status, rsp_expected_tag, rsp_found_tag);
               errors++;
            end else begin
               want = line_reports_q.pop_front();
               if (rsp_line_status !== want.status) begin
                  $display("%0t: line_status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_line_status);
                  errors++;
               end
               if (rsp_expected_tag !== want.expected) begin
                  $display("%0t: expected_tag mismatch: expected %0d, actual %0d",
                           $time, want.expected, rsp_expected_tag);
                  errors++;
               end
               if (rsp_found_tag !== want.found) begin
                  $display("%0t: found_tag mismatch: expected %0d, actual %0d",
                           $time, want.found, rsp_found_tag);
                  errors++;
               end
            end
         end
         // Hold off once for a long stretch so the request side backs up
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!stall_done && reports_seen >= 40) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else if (reports_seen >= 60 && reports_seen < 100) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
